// File: rtl/lrsr_pkg.sv
// Shared types and constants for the LR shift-reduce parse engine.
package lrsr_pkg;
   localparam int STATE_W = 10;
   localparam int TERM_W  = 6;
   localparam int NT_W    = 6;
   localparam int PROD_W  = 8;
   localparam int LEN_W   = 4;
   localparam int SP_W    = 9;
   localparam int STACK_DEPTH = 256;
   localparam int MAX_CHAIN   = 32;
   localparam int CHAIN_W     = 5;

   localparam logic [2:0] OP_TOKEN   = 3'd0;
   localparam logic [2:0] OP_ACTION  = 3'd1;
   localparam logic [2:0] OP_GOTO    = 3'd2;
   localparam logic [2:0] OP_PROD    = 3'd3;
   localparam logic [2:0] OP_RESTART = 3'd4;

   localparam logic [1:0] KIND_EMPTY  = 2'd0;
   localparam logic [1:0] KIND_SHIFT  = 2'd1;
   localparam logic [1:0] KIND_REDUCE = 2'd2;
   localparam logic [1:0] KIND_ACCEPT = 2'd3;

   localparam logic [2:0] EV_SHIFT    = 3'd0;
   localparam logic [2:0] EV_REDUCE   = 3'd1;
   localparam logic [2:0] EV_ACCEPT   = 3'd2;
   localparam logic [2:0] EV_SYNTAX   = 3'd3;
   localparam logic [2:0] EV_OVERFLOW = 3'd4;
   localparam logic [2:0] EV_CHAIN    = 3'd5;

   typedef struct packed {
      logic [2:0]         event_res;
      logic [PROD_W-1:0]  reduced_production;
      logic [NT_W-1:0]    reduced_lhs;
      logic [STATE_W-1:0] top_state;
      logic [SP_W-1:0]    stack_level;
      logic               last;
   } rsp_type;
endpackage

// File: rtl/lrsr_rsp_buf.sv
// Two-entry output buffer for the result channel; it reports room only while empty.
module lrsr_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lrsr_pkg::rsp_type push_data,
   output logic              has_room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lrsr_pkg::rsp_type rsp_data
);
   import lrsr_pkg::*;
   rsp_type   data_ff [2];
   logic [1:0] cnt_ff;
   logic       rd_ff, wr_ff;
   logic       pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_data  = data_ff[rd_ff];
   assign has_room  = cnt_ff == 2'd0;

   // track fill level and pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         if (push) begin
            data_ff[wr_ff] <= push_data;
            wr_ff <= !wr_ff;
         end
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// File: rtl/lr_shift_reduce_parse_engine_unit.sv
// Top level of the table-driven LR(1) shift-reduce parse engine.
// Load, restart and ignored items are accepted and finished while idle. A token's result passes
// the action and emit states when it shifts, accepts or misses; a length error also passes the
// production state; each reduction passes action, production, stack, goto read and emit states.
// The next item is accepted in the cycle after the last result is emitted; a full output stalls.
// After reset a clear pass zeroes every action memory entry and the bottom stack entry.
module lr_shift_reduce_parse_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [5:0]  req_terminal,
   input  logic [9:0]  req_table_state,
   input  logic [5:0]  req_nonterminal,
   input  logic [1:0]  req_action_kind,
   input  logic [9:0]  req_action_arg,
   input  logic [7:0]  req_production_index,
   input  logic [3:0]  req_production_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_reduced_production,
   output logic [5:0]  rsp_reduced_lhs,
   output logic [9:0]  rsp_top_state,
   output logic [8:0]  rsp_stack_level,
   output logic        rsp_last
);
   import lrsr_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ACT   = 3'd2;
   localparam logic [2:0] ST_PROD  = 3'd3;
   localparam logic [2:0] ST_BELOW = 3'd4;
   localparam logic [2:0] ST_GOTO  = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [11:0]        action_mem [65536];
   logic [STATE_W-1:0] goto_mem   [65536];
   logic [9:0]         prod_mem   [256];
   logic [STATE_W-1:0] stack_mem  [256];

   logic [2:0]          state_ff;
   logic [16:0]         clr_ff;
   logic [SP_W-1:0]     sp_ff;
   logic [STATE_W-1:0]  top_ff;
   logic                err_ff;
   logic [TERM_W-1:0]   term_ff;
   logic [CHAIN_W-1:0]  chain_ff;
   logic [11:0]         act_rd_ff;
   logic [9:0]          prod_rd_ff;
   logic [STATE_W-1:0]  stk_rd_ff;
   logic [STATE_W-1:0]  goto_rd_ff;
   logic [PROD_W-1:0]   pid_ff;
   logic [NT_W-1:0]     lhs_ff;
   logic [LEN_W-1:0]    len_ff;
   rsp_type             pend_ff;
   logic                push;
   logic                room;
   logic                accept;
   rsp_type             out_data;
   logic [15:0]         act_ra;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign push      = state_ff == ST_EMIT && room;

   lrsr_rsp_buf u_buf (
      .clock(clock), .reset(reset), .push(push), .push_data(pend_ff),
      .has_room(room), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_data(out_data)
   );
   assign rsp_event_res          = out_data.event_res;
   assign rsp_reduced_production = out_data.reduced_production;
   assign rsp_reduced_lhs        = out_data.reduced_lhs;
   assign rsp_top_state          = out_data.top_state;
   assign rsp_stack_level        = out_data.stack_level;
   assign rsp_last               = out_data.last;

   // look up the incoming terminal while idle, the held one during a chain
   assign act_ra = (state_ff == ST_IDLE) ? {top_ff, req_terminal} : {top_ff, term_ff};

   // action memory: clear pass, loads, lookup
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR)
         action_mem[clr_ff[15:0]] <= 12'd0;
      else if (accept && req_opcode == OP_ACTION)
         action_mem[{req_table_state, req_terminal}] <= {req_action_kind, req_action_arg};
      act_rd_ff <= action_mem[act_ra];
   end

   // goto and production memories
   always_ff @(posedge clock) begin
      if (accept && req_opcode == OP_GOTO)
         goto_mem[{req_table_state, req_nonterminal}] <= req_action_arg;
      if (accept && req_opcode == OP_PROD)
         prod_mem[req_production_index] <= {req_nonterminal, req_production_length};
      goto_rd_ff <= goto_mem[{stk_rd_ff, lhs_ff}];
      prod_rd_ff <= prod_mem[act_rd_ff[7:0]];
   end

   // stack memory
   logic             stk_we;
   logic [7:0]       stk_wa;
   logic [STATE_W-1:0] stk_wd;
   logic [SP_W-1:0]  below_idx;
   assign below_idx = sp_ff - {5'd0, prod_rd_ff[3:0]} - 9'd1;
   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_wa] <= stk_wd;
      stk_rd_ff <= stack_mem[below_idx[7:0]];
   end

   function automatic rsp_type mk(input logic [2:0] ev, input logic [7:0] p,
                                  input logic [5:0] l, input logic [9:0] t,
                                  input logic [8:0] s, input logic la);
      rsp_type r;
      r.event_res = ev; r.reduced_production = p; r.reduced_lhs = l;
      r.top_state = t; r.stack_level = s; r.last = la;
      return r;
   endfunction

   // sequencer
   logic [SP_W-1:0] sp_pop;
   assign sp_pop = sp_ff - {5'd0, len_ff};
   always_comb begin
      stk_we = 1'b0;
      stk_wa = sp_ff[7:0];
      stk_wd = act_rd_ff[9:0];
      if (state_ff == ST_ACT && act_rd_ff[11:10] == KIND_SHIFT
          && sp_ff < 9'(STACK_DEPTH))
         stk_we = 1'b1;
      if (state_ff == ST_GOTO) begin
         stk_we = 1'b1;
         stk_wa = sp_pop[7:0];
         stk_wd = goto_rd_ff;
      end
      // seed the bottom entry with state 0 on restart and during the clear pass
      if ((accept && req_opcode == OP_RESTART) || state_ff == ST_CLEAR) begin
         stk_we = 1'b1;
         stk_wa = 8'd0;
         stk_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         sp_ff    <= 9'd1;
         top_ff   <= '0;
         err_ff   <= 1'b0;
         chain_ff <= '0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 17'd1;
               if (clr_ff == 17'd65535) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) begin
                  if (req_opcode == OP_RESTART) begin
                     sp_ff  <= 9'd1;
                     top_ff <= '0;
                     err_ff <= 1'b0;
                  end else if (req_opcode == OP_TOKEN && !err_ff) begin
                     term_ff  <= req_terminal;
                     chain_ff <= '0;
                     state_ff <= ST_ACT;
                  end
               end
            end
            ST_ACT: begin
               pid_ff   <= act_rd_ff[7:0];
               state_ff <= ST_EMIT;
               case (act_rd_ff[11:10])
                  KIND_EMPTY: begin
                     err_ff  <= 1'b1;
                     pend_ff <= mk(EV_SYNTAX, 8'd0, 6'd0, top_ff, sp_ff, 1'b1);
                  end
                  KIND_ACCEPT:
                     pend_ff <= mk(EV_ACCEPT, 8'd0, 6'd0, top_ff, sp_ff, 1'b1);
                  KIND_SHIFT: begin
                     if (sp_ff >= 9'(STACK_DEPTH)) begin
                        err_ff  <= 1'b1;
                        pend_ff <= mk(EV_OVERFLOW, 8'd0, 6'd0, top_ff, sp_ff, 1'b1);
                     end else begin
                        sp_ff   <= sp_ff + 9'd1;
                        top_ff  <= act_rd_ff[9:0];
                        pend_ff <= mk(EV_SHIFT, 8'd0, 6'd0, act_rd_ff[9:0],
                                      sp_ff + 9'd1, 1'b1);
                     end
                  end
                  default: begin
                     if (chain_ff == CHAIN_W'(MAX_CHAIN - 1)) begin
                        err_ff  <= 1'b1;
                        pend_ff <= mk(EV_CHAIN, 8'd0, 6'd0, top_ff, sp_ff, 1'b1);
                     end else if (act_rd_ff[9:8] != 2'd0) begin
                        err_ff  <= 1'b1;
                        pend_ff <= mk(EV_SYNTAX, 8'd0, 6'd0, top_ff, sp_ff, 1'b1);
                     end else begin
                        state_ff <= ST_PROD;
                     end
                  end
               endcase
            end
            ST_PROD: begin
               lhs_ff <= prod_rd_ff[9:4];
               len_ff <= prod_rd_ff[3:0];
               if ({5'd0, prod_rd_ff[3:0]} >= sp_ff) begin
                  err_ff   <= 1'b1;
                  pend_ff  <= mk(EV_SYNTAX, 8'd0, 6'd0, top_ff, sp_ff, 1'b1);
                  state_ff <= ST_EMIT;
               end else if (prod_rd_ff[3:0] == 4'd0 && sp_ff >= 9'(STACK_DEPTH)) begin
                  err_ff   <= 1'b1;
                  pend_ff  <= mk(EV_OVERFLOW, 8'd0, 6'd0, top_ff, sp_ff, 1'b1);
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_BELOW;
               end
            end
            ST_BELOW: state_ff <= ST_GOTO;
            ST_GOTO: begin
               sp_ff    <= sp_pop + 9'd1;
               top_ff   <= goto_rd_ff;
               chain_ff <= chain_ff + 1'b1;
               pend_ff  <= mk(EV_REDUCE, pid_ff, lhs_ff, goto_rd_ff,
                              sp_pop + 9'd1, 1'b0);
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (room) state_ff <= pend_ff.last ? ST_IDLE : ST_ACT;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
